// File: rtl/rurs_pkg.sv
// rurs_pkg: shared types and constants of the rom used range scanner
// no dependencies; imported by every other file of the block

package rurs_pkg;

    localparam int BYTE_W     = 8;
    localparam int RUN_W      = 15;
    localparam int ADDR_W     = 25;
    localparam int LEN_W      = 15;
    localparam int MASK_W     = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int DEF_BANK_SIZE  = 16384;
    localparam int DEF_INDEX_BITS = 23;

    // banked address format is fixed at 16 KiB banks
    localparam int BANK_LOW_BITS = 14;
    localparam int BANK_SEL_BIT  = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [RUN_W-1:0]  RUN_MAX          = 15'h7FFF;
    localparam logic [RUN_W-1:0]  THR_OTHER_RESET  = 15'd17;
    localparam logic [RUN_W-1:0]  THR_ZERO_RESET   = 15'd128;
    localparam logic [MASK_W-1:0] MASK3_RESET      = 64'h8000_0000_0000_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_MASK_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_MASK_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_MASK_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_MASK_3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_THR_OTHER   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_THR_ZERO    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAT_ADDRESSES  = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              final_byte;
        logic              is_empty;
        logic [RUN_W-1:0]  run_limit;
    } rurs_entry_t;

endpackage

// File: rtl/rurs_if.sv
// rurs_if: handshake channels of the rom used range scanner
// depends on rurs_pkg

interface rurs_byte_if
    import rurs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface rurs_range_if
    import rurs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [LEN_W-1:0]  range_length;

    modport source (output valid, output range_start, output range_end,
                    output range_length, input ready);
    modport sink   (input valid, input range_start, input range_end,
                    input range_length, output ready);
endinterface

// File: rtl/rurs_front.sv
// rurs_front: configuration registers and per-item classification
// depends on rurs_pkg; feeds rurs_queue

module rurs_front
    import rurs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      byte_value,
    input  logic                   final_byte,
    input  logic                   q_ready,
    output logic                   q_push,
    output rurs_entry_t            q_entry,
    output logic                   flat
);

    logic [MASK_W-1:0] mask0_reg, mask1_reg, mask2_reg, mask3_reg;
    logic [RUN_W-1:0]  thr_other_reg, thr_zero_reg;
    logic              flat_reg;
    logic [4*MASK_W-1:0] all_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask0_reg     <= '0;
            mask1_reg     <= '0;
            mask2_reg     <= '0;
            mask3_reg     <= MASK3_RESET;
            thr_other_reg <= THR_OTHER_RESET;
            thr_zero_reg  <= THR_ZERO_RESET;
            flat_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EMPTY_MASK_0:   mask0_reg     <= cfg_data;
                CFG_EMPTY_MASK_1:   mask1_reg     <= cfg_data;
                CFG_EMPTY_MASK_2:   mask2_reg     <= cfg_data;
                CFG_EMPTY_MASK_3:   mask3_reg     <= cfg_data;
                CFG_RUN_THR_OTHER:  thr_other_reg <= cfg_data[RUN_W-1:0];
                CFG_RUN_THR_ZERO:   thr_zero_reg  <= cfg_data[RUN_W-1:0];
                CFG_FLAT_ADDRESSES: flat_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign all_mask = {mask3_reg, mask2_reg, mask1_reg, mask0_reg};

    always_comb
    begin
        q_entry.byte_value = byte_value;
        q_entry.final_byte = final_byte;
        q_entry.is_empty   = all_mask[byte_value];
        q_entry.run_limit  = (byte_value == '0) ? thr_zero_reg : thr_other_reg;
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;
    assign flat     = flat_reg;

endmodule

// File: rtl/rurs_queue.sv
// rurs_queue: short item queue between classification and the scan core
// depends on rurs_pkg

module rurs_queue
    import rurs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rurs_entry_t push_entry,
    output logic        ready,
    input  logic        pop,
    output logic        valid,
    output rurs_entry_t pop_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    rurs_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    assign ready     = (count_reg != CNT_FULL);
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/rurs_back.sv
// rurs_back: scan core, tracks runs, open range and bank position
// depends on rurs_pkg; takes items from rurs_queue, hands ranges to rurs_emit

module rurs_back
    import rurs_pkg::*;
#(
    parameter int BANK_SIZE  = DEF_BANK_SIZE,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  rurs_entry_t           q_entry,
    output logic                  q_pop,
    output logic                  cmd_valid,
    output logic [INDEX_BITS-1:0] cmd_first,
    output logic [INDEX_BITS-1:0] cmd_last,
    input  logic                  cmd_take
);

    localparam int BANK_W = $clog2(BANK_SIZE);
    localparam logic [BANK_W-1:0] BANK_LAST = BANK_W'(BANK_SIZE - 1);

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [BANK_W-1:0]     bank_cnt_reg, bank_cnt_next;
    logic                  used_open_reg, used_open_next;
    logic [INDEX_BITS-1:0] used_start_reg, used_start_next;
    logic [RUN_W-1:0]      run_len_reg, run_len_next;
    logic [BYTE_W-1:0]     run_byte_reg, run_byte_next;
    logic [RUN_W-1:0]      run_limit_reg, run_limit_next;
    logic                  cmd_valid_reg, cmd_valid_next;
    logic [INDEX_BITS-1:0] cmd_first_reg, cmd_first_next;
    logic [INDEX_BITS-1:0] cmd_last_reg, cmd_last_next;

    logic             run_hit;
    logic [RUN_W-1:0] run_inc;
    logic             bank_cut;
    logic             bank_wrap;

    assign q_pop = q_valid && (!cmd_valid_reg || cmd_take);

    always_comb
    begin
        idx_next        = idx_reg;
        bank_cnt_next   = bank_cnt_reg;
        used_open_next  = used_open_reg;
        used_start_next = used_start_reg;
        run_len_next    = run_len_reg;
        run_byte_next   = run_byte_reg;
        run_limit_next  = run_limit_reg;
        cmd_valid_next  = cmd_valid_reg && !cmd_take;
        cmd_first_next  = cmd_first_reg;
        cmd_last_next   = cmd_last_reg;

        run_hit   = (run_len_reg != '0) && (q_entry.byte_value == run_byte_reg);
        run_inc   = (run_len_reg == RUN_MAX) ? RUN_MAX : run_len_reg + RUN_W'(1);
        bank_wrap = (bank_cnt_reg == BANK_LAST);
        bank_cut  = q_entry.final_byte || bank_wrap;

        if (q_pop)
        begin
            cmd_valid_next = 1'b0;
            if (run_hit)
            begin
                run_len_next = run_inc;
                // run long enough: range ends just before the run
                if ((run_inc >= run_limit_reg) && used_open_reg)
                begin
                    used_open_next = 1'b0;
                    if (idx_reg >= INDEX_BITS'(run_inc))
                    begin
                        cmd_valid_next = 1'b1;
                        cmd_first_next = used_start_reg;
                        cmd_last_next  = idx_reg - INDEX_BITS'(run_inc);
                    end
                end
            end
            else
            begin
                // short run broken: it becomes used data
                if ((run_len_reg != '0) && (run_len_reg < run_limit_reg) && !used_open_reg)
                begin
                    used_open_next  = 1'b1;
                    used_start_next = idx_reg - INDEX_BITS'(run_len_reg);
                end
                if (q_entry.is_empty)
                begin
                    run_len_next   = RUN_W'(1);
                    run_byte_next  = q_entry.byte_value;
                    run_limit_next = q_entry.run_limit;
                end
                else
                begin
                    run_len_next = '0;
                    if (!used_open_next)
                    begin
                        used_open_next  = 1'b1;
                        used_start_next = idx_reg;
                    end
                end
            end

            if (bank_cut)
            begin
                if (used_open_next)
                begin
                    cmd_valid_next = 1'b1;
                    cmd_first_next = used_start_next;
                    cmd_last_next  = idx_reg;
                end
                used_open_next = 1'b0;
                run_len_next   = '0;
            end

            idx_next = q_entry.final_byte ? '0 : idx_reg + INDEX_BITS'(1);
            if (q_entry.final_byte || bank_wrap || (&idx_reg))
                bank_cnt_next = '0;
            else
                bank_cnt_next = bank_cnt_reg + BANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            bank_cnt_reg   <= '0;
            used_open_reg  <= 1'b0;
            used_start_reg <= '0;
            run_len_reg    <= '0;
            run_byte_reg   <= '0;
            run_limit_reg  <= '0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            bank_cnt_reg   <= bank_cnt_next;
            used_open_reg  <= used_open_next;
            used_start_reg <= used_start_next;
            run_len_reg    <= run_len_next;
            run_byte_reg   <= run_byte_next;
            run_limit_reg  <= run_limit_next;
            cmd_valid_reg  <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_first_reg <= cmd_first_next;
        cmd_last_reg  <= cmd_last_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_first = cmd_first_reg;
    assign cmd_last  = cmd_last_reg;

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_entry.final_byte |=> idx_reg == '0 && bank_cnt_reg == '0)
        else $error("index not restarted after final item");

    a_bank_closes: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && bank_cut |=> !used_open_reg && run_len_reg == '0)
        else $error("range or run left open across bank end");

    a_cmd_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !cmd_take |=>
            cmd_valid_reg && $stable(cmd_first_reg) && $stable(cmd_last_reg))
        else $error("pending range lost while emit stage stalled");

endmodule

// File: rtl/rurs_emit.sv
// rurs_emit: address translation, length and the output register
// depends on rurs_pkg; takes closed ranges from rurs_back

module rurs_emit
    import rurs_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  flat,
    input  logic                  cmd_valid,
    input  logic [INDEX_BITS-1:0] cmd_first,
    input  logic [INDEX_BITS-1:0] cmd_last,
    output logic                  cmd_take,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     range_start,
    output logic [ADDR_W-1:0]     range_end,
    output logic [LEN_W-1:0]      range_length
);

    localparam int TW = INDEX_BITS + 2;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] start_reg, end_reg;
    logic [LEN_W-1:0]  len_reg;

    logic              out_free;
    logic [TW-1:0]     s_addr, e_addr, diff;
    logic              backward;
    logic [LEN_W-1:0]  len_calc;

    function automatic logic [TW-1:0] translate(input logic [INDEX_BITS-1:0] a,
                                                input logic flat_mode);
        logic [TW-1:0] t;
        begin
            t = {a[INDEX_BITS-1:BANK_LOW_BITS], 2'b00, a[BANK_LOW_BITS-1:0]};
            // bits 15:14 are zero here, so the bank offset add is an or
            if (|t[TW-1:BANK_SEL_BIT])
                t[BANK_LOW_BITS] = 1'b1;
            if (flat_mode)
                t = TW'(a);
            return t;
        end
    endfunction

    always_comb
    begin
        s_addr   = translate(cmd_first, flat);
        e_addr   = translate(cmd_last, flat);
        backward = (e_addr < s_addr);
        diff     = e_addr - s_addr;
        if (diff >= TW'(RUN_MAX))
            len_calc = RUN_MAX;
        else
            len_calc = diff[LEN_W-1:0] + LEN_W'(1);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign cmd_take = cmd_valid && out_free;

    always_comb
    begin
        if (out_free)
            out_valid_next = cmd_valid && !backward;
        else
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            start_reg <= ADDR_W'(s_addr);
            end_reg   <= ADDR_W'(e_addr);
            len_reg   <= len_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign range_start  = start_reg;
    assign range_end    = end_reg;
    assign range_length = len_reg;

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> len_reg != '0)
        else $error("range with zero length");

    a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && len_reg != RUN_MAX |->
            end_reg - start_reg + ADDR_W'(1) == ADDR_W'(len_reg))
        else $error("range length does not match its bounds");

    a_forward_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && !backward |=> out_valid_reg)
        else $error("taken range not presented");

endmodule

// File: rtl/rom_used_range_scanner.sv
// channel    | dir | payload                                  | handshake
// byte_in    | in  | byte_value, final_byte                   | valid/ready
// range_out  | out | range_start, range_end, range_length     | valid/ready
// cfg        | in  | cfg_index, cfg_data                      | cfg_we, no stall
//
// one item per cycle sustained while range_out is ready; a range is registered in order in the
// queue slot, the scan core range register and the emit output register
// reset clears the queue, scan state and output valid; config returns to defaults
// a stalled output holds one range and one pending range, then the queue fills
// and byte_in.ready drops
// depends on rurs_pkg, rurs_if, rurs_front, rurs_queue, rurs_back, rurs_emit

module rom_used_range_scanner
    import rurs_pkg::*;
#(
    parameter int BANK_SIZE  = DEF_BANK_SIZE,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rurs_byte_if.sink              byte_in,
    rurs_range_if.source           range_out
);

    logic                  flat;
    logic                  q_ready, q_push, q_valid, q_pop;
    rurs_entry_t           push_entry, pop_entry;
    logic                  cmd_valid, cmd_take;
    logic [INDEX_BITS-1:0] cmd_first, cmd_last;

    rurs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (byte_in.valid),
        .in_ready   (byte_in.ready),
        .byte_value (byte_in.byte_value),
        .final_byte (byte_in.final_byte),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_entry    (push_entry),
        .flat       (flat)
    );

    rurs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (pop_entry)
    );

    rurs_back #(
        .BANK_SIZE  (BANK_SIZE),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .cmd_valid (cmd_valid),
        .cmd_first (cmd_first),
        .cmd_last  (cmd_last),
        .cmd_take  (cmd_take)
    );

    rurs_emit #(
        .INDEX_BITS (INDEX_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .flat         (flat),
        .cmd_valid    (cmd_valid),
        .cmd_first    (cmd_first),
        .cmd_last     (cmd_last),
        .cmd_take     (cmd_take),
        .out_valid    (range_out.valid),
        .out_ready    (range_out.ready),
        .range_start  (range_out.range_start),
        .range_end    (range_out.range_end),
        .range_length (range_out.range_length)
    );

endmodule

// File: tb/rurs_range_checker.sv
`timescale 1ns / 100ps
// rurs_range_checker: watches the byte, range and register ports of the scanner,
// predicts each used range from the accepted items and compares the ranges handed out
// depends on rurs_pkg

module rurs_range_checker
    import rurs_pkg::*;
#(
    parameter int BANK_SIZE  = DEF_BANK_SIZE,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   byte_valid,
    input  logic                   byte_ready,
    input  logic [BYTE_W-1:0]      byte_value,
    input  logic                   final_byte,
    input  logic                   range_valid,
    input  logic                   range_ready,
    input  logic [ADDR_W-1:0]      range_start,
    input  logic [ADDR_W-1:0]      range_end,
    input  logic [LEN_W-1:0]       range_length,
    output int                     mismatches,
    output int                     ranges_pending,
    output int                     ranges_checked
);

    typedef struct packed {
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] last_addr;
        logic [LEN_W-1:0]  length;
    } used_range_t;

    localparam logic [63:0] BANK_LOW_MASK = (64'd1 << BANK_LOW_BITS) - 64'd1;
    localparam logic [63:0] INDEX_MASK    = (64'd1 << INDEX_BITS) - 64'd1;

    used_range_t       expected_ranges[$];
    used_range_t       oldest;
    logic [MASK_W-1:0] empty_flags [4];
    logic [RUN_W-1:0]  thr_other;
    logic [RUN_W-1:0]  thr_zero;
    logic              flat;
    logic [63:0]       scan_index;
    logic [63:0]       open_start;
    logic              range_open;
    logic [RUN_W-1:0]  run_len;
    logic [RUN_W-1:0]  run_limit;
    logic [BYTE_W-1:0] run_value;
    int                fail_total = 0;
    int                compared = 0;

    function automatic logic [63:0] bank_addr(input logic [63:0] a);
        logic [63:0] t;
        if (flat)
            return a;
        t = (a & BANK_LOW_MASK) | ((a & ~BANK_LOW_MASK) << (BANK_SEL_BIT - BANK_LOW_BITS));
        if ((t >> BANK_SEL_BIT) != 64'd0)
            t = t + BANK_LOW_MASK + 64'd1;
        return t;
    endfunction

    function automatic bit queue_range(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] len;
        used_range_t r;
        s = bank_addr(lo);
        e = bank_addr(hi);
        if (e < s)
            return 1'b0;
        len = e - s + 64'd1;
        if (len > RUN_MAX)
            len = RUN_MAX;
        r.first_addr = s[ADDR_W-1:0];
        r.last_addr  = e[ADDR_W-1:0];
        r.length     = len[LEN_W-1:0];
        expected_ranges.push_back(r);
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        fail_total++;
        if (fail_total <= 100)
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [63:0] idx;
        bit          got;
        logic        value_empty;
        idx = scan_index & INDEX_MASK;
        got = 1'b0;
        value_empty = empty_flags[b[7:6]][b[5:0]];
        if (run_len != '0 && b == run_value)
        begin
            if (run_len < RUN_MAX)
                run_len = run_len + 1'b1;
            if (run_len >= run_limit && range_open)
            begin
                if (idx >= run_len)
                    got = queue_range(open_start, (idx - run_len) & INDEX_MASK);
                range_open = 1'b0;
            end
        end
        else
        begin
            // a run that ended short counts as used data
            if (run_len != '0 && run_len < run_limit && !range_open)
            begin
                range_open = 1'b1;
                open_start = (idx - run_len) & INDEX_MASK;
            end
            if (value_empty)
            begin
                run_len   = RUN_W'(1);
                run_value = b;
                run_limit = (b == '0) ? thr_zero : thr_other;
            end
            else
            begin
                run_len = '0;
                if (!range_open)
                begin
                    range_open = 1'b1;
                    open_start = idx;
                end
            end
        end
        if (fin || (idx % BANK_SIZE) == BANK_SIZE - 1)
        begin
            if (range_open && !got)
                got = queue_range(open_start, idx);
            range_open = 1'b0;
            run_len    = '0;
        end
        scan_index = fin ? 64'd0 : ((idx + 64'd1) & INDEX_MASK);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_flags[0] = '0;
            empty_flags[1] = '0;
            empty_flags[2] = '0;
            empty_flags[3] = MASK3_RESET;
            thr_other  = THR_OTHER_RESET;
            thr_zero   = THR_ZERO_RESET;
            flat       = 1'b0;
            scan_index = '0;
            open_start = '0;
            range_open = 1'b0;
            run_len    = '0;
            run_limit  = '0;
            run_value  = '0;
            expected_ranges.delete();
            mismatches     <= fail_total;
            ranges_pending <= 0;
            ranges_checked <= compared;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EMPTY_MASK_0, CFG_EMPTY_MASK_1, CFG_EMPTY_MASK_2, CFG_EMPTY_MASK_3:
                        empty_flags[cfg_index[1:0]] = cfg_data;
                    CFG_RUN_THR_OTHER:  thr_other = cfg_data[RUN_W-1:0];
                    CFG_RUN_THR_ZERO:   thr_zero = cfg_data[RUN_W-1:0];
                    CFG_FLAT_ADDRESSES: flat = cfg_data[0];
                    default: ;
                endcase
            end
            if (range_valid && range_ready)
            begin
                compared++;
                if (expected_ranges.size() == 0)
                    report("range with nothing expected", range_start, 64'd0);
                else
                begin
                    oldest = expected_ranges.pop_front();
                    if (range_start !== oldest.first_addr)
                        report("range_start", range_start, oldest.first_addr);
                    if (range_end !== oldest.last_addr)
                        report("range_end", range_end, oldest.last_addr);
                    if (range_length !== oldest.length)
                        report("range_length", range_length, oldest.length);
                end
            end
            if (byte_valid && byte_ready)
                scan_byte(byte_value, final_byte);
            mismatches     <= fail_total;
            ranges_pending <= expected_ranges.size();
            ranges_checked <= compared;
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset, register settings and image byte stimulus for the scanner,
// with random sender gaps and receiver stalls; gives the verdict
// depends on rurs_pkg, rurs_if, rom_used_range_scanner and rurs_range_checker

module tb_top;
    import rurs_pkg::*;

    localparam int BANK_SIZE     = DEF_BANK_SIZE;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 450;

    // {final_byte, byte_value}
    localparam logic [8:0] DIRECTED [13] = '{
        9'h141,
        9'h1FF,
        9'h000, 9'h0FF, 9'h180,
        9'h012, 9'h0FF, 9'h0FF, 9'h0FF, 9'h134,
        9'h0FF, 9'h0FF, 9'h155
    };

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    rurs_byte_if  byte_ch ();
    rurs_range_if range_ch ();

    int                mismatches;
    int                ranges_pending;
    int                ranges_checked;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                bytes_sent = 0;
    int                images_sent = 0;
    int                settings_used = 0;
    stall_mode_t       stall_mode = STALL_NONE;
    int                mode_left = 0;
    logic [MASK_W-1:0] cur_mask [4];
    logic [RUN_W-1:0]  cur_thr_other;
    logic [RUN_W-1:0]  cur_thr_zero;
    logic              cur_flat;
    logic [BYTE_W-1:0] image_bytes[$];

    always #4 clk = ~clk;

    rom_used_range_scanner dut (
        .clk,
        .rst_n,
        .cfg_we,
        .cfg_index,
        .cfg_data,
        .byte_in   (byte_ch),
        .range_out (range_ch)
    );

    rurs_range_checker #(
        .BANK_SIZE  (BANK_SIZE),
        .INDEX_BITS (DEF_INDEX_BITS)
    ) range_check (
        .clk,
        .rst_n,
        .cfg_we,
        .cfg_index,
        .cfg_data,
        .byte_valid     (byte_ch.valid),
        .byte_ready     (byte_ch.ready),
        .byte_value     (byte_ch.byte_value),
        .final_byte     (byte_ch.final_byte),
        .range_valid    (range_ch.valid),
        .range_ready    (range_ch.ready),
        .range_start    (range_ch.range_start),
        .range_end      (range_ch.range_end),
        .range_length   (range_ch.range_length),
        .mismatches     (mismatches),
        .ranges_pending (ranges_pending),
        .ranges_checked (ranges_checked)
    );

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 150);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            STALL_NONE:  range_ch.ready <= 1'b1;
            STALL_LIGHT: range_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: range_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     range_ch.ready <= ~range_ch.ready;
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d ranges outstanding", cycle_count,
                     ranges_pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        if (burst_left == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= b;
        byte_ch.final_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        if (fin)
            images_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (ranges_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic program_registers();
        wait_drained();
        for (int m = 0; m < 4; m++)
            write_reg(CFG_EMPTY_MASK_0 + CFG_INDEX_W'(m), cur_mask[m]);
        write_reg(CFG_RUN_THR_OTHER, CFG_DATA_W'(cur_thr_other));
        write_reg(CFG_RUN_THR_ZERO, CFG_DATA_W'(cur_thr_zero));
        write_reg(CFG_FLAT_ADDRESSES, CFG_DATA_W'(cur_flat));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            4: return {$urandom, $urandom};
            default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [RUN_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return RUN_W'(2);
            1: return RUN_W'(BANK_SIZE);
            2: return THR_OTHER_RESET;
            default: return RUN_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic pick_setting(input int phase);
        if (phase == 0)
        begin
            cur_mask      = '{'1, '1, '1, '1};
            cur_thr_other = RUN_W'(2);
            cur_thr_zero  = RUN_W'(2);
            cur_flat      = 1'b1;
        end
        else if (phase == 1)
        begin
            cur_mask      = '{'0, '0, '0, '0};
            cur_thr_other = RUN_W'(BANK_SIZE);
            cur_thr_zero  = RUN_W'(BANK_SIZE);
            cur_flat      = 1'b0;
        end
        else
        begin
            for (int m = 0; m < 4; m++)
                cur_mask[m] = pick_mask();
            if ($urandom_range(0, 1) == 1)
                cur_mask[0][0] = 1'b1;
            if ($urandom_range(0, 1) == 1)
                cur_mask[3][63] = 1'b1;
            cur_thr_other = pick_threshold();
            cur_thr_zero  = pick_threshold();
            cur_flat      = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic add_run();
        logic [BYTE_W-1:0] v;
        logic [RUN_W-1:0]  thr;
        int                len;
        v = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom_range(0, 255));
        for (int t = 0; t < 16 && !cur_mask[v[7:6]][v[5:0]]; t++)
            v = BYTE_W'($urandom_range(0, 255));
        thr = (v == '0) ? cur_thr_zero : cur_thr_other;
        if (thr > 64)
            len = $urandom_range(1, 6);
        else
        begin
            case ($urandom_range(0, 3))
                0: len = thr - 1;
                1: len = thr;
                2: len = thr + $urandom_range(1, 3);
                default: len = $urandom_range(1, 4);
            endcase
        end
        repeat (len) image_bytes.push_back(v);
    endtask

    task automatic build_image(input int target);
        image_bytes.delete();
        while (image_bytes.size() < target)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 6)) image_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else
                add_run();
        end
    endtask

    task automatic send_image();
        for (int i = 0; i < image_bytes.size(); i++)
            send_byte(image_bytes[i], i == image_bytes.size() - 1);
    endtask

    initial
    begin
        int phase;
        byte_ch.valid      = 1'b0;
        byte_ch.byte_value = '0;
        byte_ch.final_byte = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_mask      = '{'0, '0, '0, MASK3_RESET};
        cur_thr_other = RUN_W'(3);
        cur_thr_zero  = THR_ZERO_RESET;
        cur_flat      = 1'b0;
        program_registers();
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        phase = 0;
        while (bytes_sent < RANDOM_BYTES + $size(DIRECTED))
        begin
            pick_setting(phase);
            program_registers();
            phase++;
            repeat ($urandom_range(2, 6))
            begin
                if (bytes_sent < RANDOM_BYTES + $size(DIRECTED))
                begin
                    if ($urandom_range(0, 7) == 0)
                        wait_drained();
                    build_image(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                            : $urandom_range(1, 30));
                    send_image();
                end
            end
        end

        wait_drained();
        $display("sent %0d bytes in %0d images under %0d register settings", bytes_sent,
                 images_sent, settings_used);
        $display("compared %0d ranges, %0d mismatches", ranges_checked, mismatches);
        if (mismatches == 0 && ranges_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
